FILE: hw/rtl/assert_macros.svh
// assertion helpers for the route table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold outside reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain clocked property
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/iprt_pkg.sv
package iprt_pkg;

    localparam int TableDepth = 32;
    localparam int IfaceCount = 8;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);

    typedef logic [1:0] t_cmd;
    localparam t_cmd CmdAdd    = 2'd0;
    localparam t_cmd CmdDelete = 2'd1;
    localparam t_cmd CmdLookup = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status StOk       = 2'd0;
    localparam t_status StNotFound = 2'd1;
    localparam t_status StNoRoute  = 2'd2;
    localparam t_status StFull     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_RESULT, S_HOLD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat, clear scan
        logic write_new; // add: write entry at count
        logic scan_step; // compare entry at scan index, advance
        logic shift_step;// move entry idx+1 down to idx
        logic finish;    // form result register
        logic [1:0] fin_kind; // status selector for finish
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic scan_done;  // scan index reached count
        logic del_hit;    // delete match in current compare
        logic shift_done; // shift reached last live slot
        logic found;
    } t_sts;

    function automatic logic [5:0] prefix_of_mask(input logic [31:0] m);
        logic [5:0] p;
        p = 6'd0;
        for (int k = 31; k >= 0; k--) begin
            if (m[k]) p = 6'(32 - k);
        end
        return p;
    endfunction

    function automatic logic [31:0] mask_of_prefix(input logic [5:0] p);
        logic [31:0] m;
        if (p == 6'd0) m = 32'd0;
        else if (p >= 6'd32) m = 32'hFFFF_FFFF;
        else m = 32'hFFFF_FFFF << (6'd32 - p);
        return m;
    endfunction

endpackage

FILE: hw/rtl/iprt_ctrl.sv
`include "assert_macros.svh"
module iprt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    input  iprt_pkg::t_cmd    i_cmd,
    input  logic              i_out_fire,
    input  iprt_pkg::t_sts    i_sts,
    output iprt_pkg::t_ctl    o_ctl,
    output logic              o_in_ready,
    output logic              o_out_valid
);
    iprt_pkg::t_state r_state, n_state;
    iprt_pkg::t_cmd   r_cmd, n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iprt_pkg::S_IDLE;
            r_cmd   <= iprt_pkg::CmdAdd;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        o_ctl = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            iprt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_ctl.load = 1'b1;
                    n_cmd = i_cmd;
                    n_state = (i_cmd == iprt_pkg::CmdDelete || i_cmd == iprt_pkg::CmdLookup)
                        ? iprt_pkg::S_SCAN : iprt_pkg::S_RESULT;
                end
            end
            iprt_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = iprt_pkg::S_RESULT;
                end else if (r_cmd == iprt_pkg::CmdDelete && i_sts.del_hit) begin
                    n_state = iprt_pkg::S_SHIFT;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            iprt_pkg::S_SHIFT: begin
                o_ctl.shift_step = 1'b1;
                if (i_sts.shift_done) n_state = iprt_pkg::S_RESULT;
            end
            iprt_pkg::S_RESULT: begin
                o_ctl.finish = 1'b1;
                o_ctl.fin_kind = r_cmd;
                if (r_cmd == iprt_pkg::CmdAdd && !i_sts.full) o_ctl.write_new = 1'b1;
                n_state = iprt_pkg::S_HOLD;
            end
            iprt_pkg::S_HOLD: begin
                o_out_valid = 1'b1;
                if (i_out_fire) n_state = iprt_pkg::S_IDLE;
            end
            default: n_state = iprt_pkg::S_IDLE;
        endcase
    end

    `ASSERT_RST(a_shift_only_delete, i_clk, i_rst_n,
        (r_state == iprt_pkg::S_SHIFT) |-> (r_cmd == iprt_pkg::CmdDelete), "shift outside delete")
    `ASSERT_RST(a_hold_after_result, i_clk, i_rst_n,
        (r_state == iprt_pkg::S_RESULT) |=> (r_state == iprt_pkg::S_HOLD), "result not held")
    `ASSERT_RST(a_no_accept_busy, i_clk, i_rst_n,
        o_out_valid |-> !o_in_ready, "accept while result pending")
endmodule

FILE: hw/rtl/iprt_datapath.sv
`include "assert_macros.svh"
module iprt_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iprt_pkg::t_ctl       i_ctl,
    input  logic [1:0]           i_cmd,
    input  logic [31:0]          i_dest,
    input  logic [31:0]          i_gw,
    input  logic [31:0]          i_mask,
    input  logic [2:0]           i_iface,
    input  logic                 i_via,
    input  logic [7:0]           i_up_mask,
    output iprt_pkg::t_sts       o_sts,
    output logic [1:0]           o_status,
    output logic [31:0]          o_route_gw,
    output logic [2:0]           o_route_iface,
    output logic                 o_route_flag
);
    localparam int IW = iprt_pkg::IdxW;
    localparam int CW = iprt_pkg::CntW;

    logic [31:0] r_mem_dest [iprt_pkg::TableDepth];
    logic [31:0] r_mem_gw   [iprt_pkg::TableDepth];
    logic [9:0]  r_mem_attr [iprt_pkg::TableDepth];

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [31:0] r_dest, r_gw, r_mask;
    logic [5:0]  r_prefix;
    logic [2:0]  r_iface;
    logic        r_via;
    logic        r_found;
    logic        r_del_hit;
    logic [5:0]  r_best_p;
    logic [31:0] r_best_gw;
    logic [3:0]  r_best_attr;
    logic [1:0]  r_status;
    logic [31:0] r_out_gw;
    logic [2:0]  r_out_iface;
    logic        r_out_flag;

    logic [IW-1:0] rd_idx, nx_idx;
    logic [31:0] e_dest, e_gw;
    logic [9:0]  e_attr;
    logic [31:0] lmask;
    logic        up, look_hit, del_hit;

    assign rd_idx = r_idx[IW-1:0];
    assign nx_idx = IW'(r_idx + CW'(1));
    assign e_dest = r_mem_dest[rd_idx];
    assign e_gw   = r_mem_gw[rd_idx];
    assign e_attr = r_mem_attr[rd_idx];
    assign lmask  = iprt_pkg::mask_of_prefix(e_attr[5:0]);
    assign up = (32'(e_attr[8:6]) < 32'(iprt_pkg::IfaceCount)) && i_up_mask[e_attr[8:6]];
    assign look_hit = up && ((e_dest & lmask) == (r_dest & lmask));
    assign del_hit = (e_attr[5:0] == r_prefix) && ((e_dest & r_mask) == (r_dest & r_mask));

    assign o_sts.full = (r_count >= CW'(iprt_pkg::TableDepth));
    assign o_sts.scan_done = (r_idx >= r_count);
    assign o_sts.del_hit = del_hit;
    assign o_sts.shift_done = (r_idx + CW'(1) >= r_count);
    assign o_sts.found = r_found;

    always_ff @(posedge i_clk) begin
        if (i_ctl.write_new) begin
            r_mem_dest[r_count[IW-1:0]] <= r_dest;
            r_mem_gw[r_count[IW-1:0]]   <= r_gw;
            r_mem_attr[r_count[IW-1:0]] <= {r_via, r_iface, r_prefix};
        end else if (i_ctl.shift_step && !o_sts.shift_done) begin
            r_mem_dest[rd_idx] <= r_mem_dest[nx_idx];
            r_mem_gw[rd_idx]   <= r_mem_gw[nx_idx];
            r_mem_attr[rd_idx] <= r_mem_attr[nx_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_del_hit <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_idx <= '0;
                r_found <= 1'b0;
                r_del_hit <= 1'b0;
            end else if (i_ctl.scan_step) begin
                r_idx <= r_idx + CW'(1);
                if (look_hit && (!r_found || e_attr[5:0] > r_best_p)) r_found <= 1'b1;
            end else if (i_ctl.shift_step) begin
                r_idx <= r_idx + CW'(1);
                r_del_hit <= 1'b1;
                if (o_sts.shift_done) r_count <= r_count - CW'(1);
            end
            if (i_ctl.write_new) r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dest <= i_dest;
            r_gw <= i_gw;
            r_mask <= i_mask;
            r_prefix <= iprt_pkg::prefix_of_mask(i_mask);
            r_iface <= i_iface;
            r_via <= i_via;
        end
        if (i_ctl.scan_step && look_hit && (!r_found || e_attr[5:0] > r_best_p)) begin
            r_best_p <= e_attr[5:0];
            r_best_gw <= e_gw;
            r_best_attr <= e_attr[9:6];
        end
        if (i_ctl.finish) begin
            r_out_gw <= '0;
            r_out_iface <= '0;
            r_out_flag <= 1'b0;
            unique case (i_ctl.fin_kind)
                iprt_pkg::CmdAdd:
                    r_status <= o_sts.full ? iprt_pkg::StFull : iprt_pkg::StOk;
                iprt_pkg::CmdDelete:
                    r_status <= r_del_hit ? iprt_pkg::StOk : iprt_pkg::StNotFound;
                iprt_pkg::CmdLookup: begin
                    if (r_found) begin
                        r_status <= iprt_pkg::StOk;
                        r_out_gw <= r_best_gw;
                        r_out_iface <= r_best_attr[2:0];
                        r_out_flag <= r_best_attr[3];
                    end else begin
                        r_status <= iprt_pkg::StNoRoute;
                    end
                end
                default: r_status <= iprt_pkg::StOk;
            endcase
        end
    end

    assign o_status = r_status;
    assign o_route_gw = r_out_gw;
    assign o_route_iface = r_out_iface;
    assign o_route_flag = r_out_flag;

    // i_cmd only used for checking
    `ASSERT_RST(a_count_bound, i_clk, i_rst_n,
        r_count <= CW'(iprt_pkg::TableDepth), "entry count over depth")
    `ASSERT_RST(a_load_clears, i_clk, i_rst_n,
        i_ctl.load |=> (r_idx == '0 && !r_found), "scan not restarted")
    `ASSERT_RST(a_write_add, i_clk, i_rst_n,
        i_ctl.load && (i_cmd == iprt_pkg::CmdLookup) |=> !i_ctl.write_new,
        "write after lookup")
endmodule

FILE: hw/rtl/ipv4_prefix_route_table.sv
// channel  | group       | beat contents (low bit up)
// input    | s_axis_*    | tdata: command[1:0] dest_addr[33:2] gateway_addr[65:34]
//          |             |        net_mask[97:66] iface_select[100:98] via_gateway[101]
// output   | m_axis_*    | tdata: status[1:0] route_gateway[33:2] route_iface[36:34]
//          |             |        route_is_gateway[37]
// config   | i_cfg_*     | interface_up_mask, written when i_cfg_we is high
//
// add skips the scan: the entry is written at the entry count when the result is formed
// delete and lookup scan the entries from slot 0, one entry per cycle;
// a delete hit stops the scan and shifts the later entries down one slot at a time
// the entry memory read at the scan index sets the scan rate
// synchronous active-low reset clears the entry count and config register
// one beat at a time: input is refused until the result beat is taken
module ipv4_prefix_route_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // command, dest_addr, gateway_addr, net_mask,
                                        // iface_select, via_gateway
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // status, route_gateway, route_iface, route_is_gateway
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata
);
    iprt_pkg::t_ctl ctl;
    iprt_pkg::t_sts sts;
    logic [7:0] r_up_mask;
    logic [1:0] status;
    logic [31:0] route_gw;
    logic [2:0] route_iface;
    logic route_flag;

    // interface up mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_up_mask <= '0;
        else if (i_cfg_we) r_up_mask <= i_cfg_wdata;
    end

    iprt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_fire(s_axis_tvalid && s_axis_tready),
        .i_cmd(s_axis_tdata[1:0]),
        .i_out_fire(m_axis_tvalid && m_axis_tready),
        .i_sts(sts), .o_ctl(ctl),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid)
    );

    iprt_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl),
        .i_cmd(s_axis_tdata[1:0]),
        .i_dest(s_axis_tdata[33:2]), .i_gw(s_axis_tdata[65:34]),
        .i_mask(s_axis_tdata[97:66]), .i_iface(s_axis_tdata[100:98]),
        .i_via(s_axis_tdata[101]), .i_up_mask(r_up_mask),
        .o_sts(sts), .o_status(status), .o_route_gw(route_gw),
        .o_route_iface(route_iface), .o_route_flag(route_flag)
    );

    assign m_axis_tdata = {2'b00, route_flag, route_iface, route_gw, status};
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int Depth = 32;
    localparam logic [1:0] CmdUnused = 2'd3;

    // one route request beat as packed on s_axis_tdata
    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] dest;
        logic [31:0] gw;
        logic [31:0] mask;
        logic [2:0]  iface;
        logic        via_gw;
    } t_req;

    // one answer beat as packed on m_axis_tdata
    typedef struct {
        logic [1:0]  status;
        logic [31:0] gw;
        logic [2:0]  iface;
        logic        is_gw;
    } t_ans;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;  // command, dest_addr, gateway_addr, net_mask,
                                      // iface_select, via_gateway
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;       // status, route_gateway, route_iface, route_is_gateway
    logic         i_cfg_we = 1'b0;
    logic [7:0]   i_cfg_wdata = '0;

    always #4 i_clk = ~i_clk;

    ipv4_prefix_route_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // shadow routing table, oldest route in slot 0
    logic [31:0] rt_dest [Depth];
    logic [31:0] rt_gw   [Depth];
    logic [5:0]  rt_plen [Depth];
    logic [2:0]  rt_if   [Depth];
    logic        rt_flag [Depth];
    int          rt_count = 0;
    logic [7:0]  up_mask = 8'd0;

    t_req pending_reqs[$];
    t_ans expected_answers[$];
    int   fail_count = 0;
    bit   drain_hold = 1'b0;  // sender waits for the table to go quiet

    function automatic logic [5:0] plen_of(logic [31:0] m);
        for (int k = 0; k < 32; k++)
            if (m[k]) return 6'(32 - k);
        return 6'd0;
    endfunction

    function automatic logic [31:0] pmask_of(logic [5:0] p);
        if (p == 0) return 32'd0;
        if (p >= 32) return 32'hFFFF_FFFF;
        return 32'hFFFF_FFFF << (32 - p);
    endfunction

    // apply one request to the shadow table, return the answer it yields
    function automatic t_ans route_table_apply(t_req r);
        t_ans a;
        int hit;
        int best;
        logic [5:0] p;
        logic [31:0] m;
        a = '{iprt_pkg::StOk, 32'd0, 3'd0, 1'b0};
        case (r.cmd)
            iprt_pkg::CmdAdd: begin
                if (rt_count >= Depth) begin
                    a.status = iprt_pkg::StFull;
                end else begin
                    rt_dest[rt_count] = r.dest;
                    rt_gw[rt_count] = r.gw;
                    rt_plen[rt_count] = plen_of(r.mask);
                    rt_if[rt_count] = r.iface;
                    rt_flag[rt_count] = r.via_gw;
                    rt_count++;
                end
            end
            iprt_pkg::CmdDelete: begin
                p = plen_of(r.mask);
                hit = -1;
                for (int i = 0; i < rt_count; i++)
                    if (hit < 0 && rt_plen[i] == p && (rt_dest[i] & r.mask) == (r.dest & r.mask))
                        hit = i;
                if (hit < 0) begin
                    a.status = iprt_pkg::StNotFound;
                end else begin
                    // later routes slide down, order kept
                    for (int i = hit; i + 1 < rt_count; i++) begin
                        rt_dest[i] = rt_dest[i+1];
                        rt_gw[i] = rt_gw[i+1];
                        rt_plen[i] = rt_plen[i+1];
                        rt_if[i] = rt_if[i+1];
                        rt_flag[i] = rt_flag[i+1];
                    end
                    rt_count--;
                end
            end
            iprt_pkg::CmdLookup: begin
                best = -1;
                for (int i = 0; i < rt_count; i++) begin
                    m = pmask_of(rt_plen[i]);
                    // strict compare keeps the oldest route on ties
                    if (up_mask[rt_if[i]] && (rt_dest[i] & m) == (r.dest & m)
                        && (best < 0 || rt_plen[i] > rt_plen[best]))
                        best = i;
                end
                if (best < 0) begin
                    a.status = iprt_pkg::StNoRoute;
                end else begin
                    a.gw = rt_gw[best];
                    a.iface = rt_if[best];
                    a.is_gw = rt_flag[best];
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    // driver: bursts with random gaps, holds off while drain_hold is set
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_answers.push_back(route_table_apply(pending_reqs.pop_front()));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !drain_hold) begin
                    t_req r;
                    r = pending_reqs[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {2'b0, r.via_gw, r.iface, r.mask, r.gw, r.dest, r.cmd};
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern: long ready runs mixed with choppy stretches
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 300;
        if (stall_phase < 100) m_axis_tready <= 1'b1;
        else if (stall_phase < 200) m_axis_tready <= ($urandom_range(0, 3) != 0);
        else m_axis_tready <= ($urandom_range(0, 4) == 0);
    end

    // monitor: compare each answer beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_answers.size() == 0) begin
                $error("answer beat with nothing pending: %h", m_axis_tdata);
                fail_count++;
            end else begin
                t_ans e;
                e = expected_answers.pop_front();
                if (m_axis_tdata[1:0] !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_axis_tdata[1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[33:2] !== e.gw) begin
                    $error("route_gateway exp %h got %h", e.gw, m_axis_tdata[33:2]);
                    fail_count++;
                end
                if (m_axis_tdata[36:34] !== e.iface) begin
                    $error("route_iface exp %0d got %0d", e.iface, m_axis_tdata[36:34]);
                    fail_count++;
                end
                if (m_axis_tdata[37] !== e.is_gw) begin
                    $error("route_is_gateway exp %0d got %0d", e.is_gw, m_axis_tdata[37]);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_mask();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();  // non-contiguous
            default: return pmask_of(6'($urandom_range(1, 32)));
        endcase
    endfunction

    function automatic t_req make_req(logic [1:0] c, logic [31:0] d, logic [31:0] m);
        t_req r;
        r.cmd = c;
        r.dest = d;
        r.gw = $urandom();
        r.mask = m;
        r.iface = 3'($urandom_range(0, 7));
        r.via_gw = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // wait until every queued beat is out and answered, then let the block settle
    task automatic wait_quiet();
        while (pending_reqs.size() > 0 || expected_answers.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_up_mask(logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        up_mask = v;
    endtask

    logic [31:0] known_dest [$];
    logic [31:0] known_mask [$];

    initial begin
        t_req r;
        int pick;
        logic [7:0] phase_masks [5];
        phase_masks = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h0F};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lookup on empty table, extremes, special cases
        write_up_mask(8'hFF);
        pending_reqs.push_back(make_req(iprt_pkg::CmdLookup, 32'd0, 32'd0));
        pending_reqs.push_back(make_req(iprt_pkg::CmdDelete, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        r = make_req(iprt_pkg::CmdAdd, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        r.gw = 32'hFFFF_FFFF; r.iface = 3'd7; r.via_gw = 1'b1;
        pending_reqs.push_back(r);
        r = make_req(iprt_pkg::CmdAdd, 32'h0A00_0000, 32'hFF00_0000);
        r.gw = 32'h0; r.iface = 3'd0; r.via_gw = 1'b0;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(iprt_pkg::CmdAdd, 32'h0A01_0000, 32'hFFFF_0000));
        pending_reqs.push_back(make_req(iprt_pkg::CmdAdd, 32'h0A01_0000, 32'hFFFF_0000)); // tie
        pending_reqs.push_back(make_req(iprt_pkg::CmdAdd, 32'h0, 32'h0));             // default
        pending_reqs.push_back(make_req(iprt_pkg::CmdAdd, 32'h0B00_0000, 32'hF0F0_0100)); // holes
        pending_reqs.push_back(make_req(iprt_pkg::CmdLookup, 32'h0A01_0203, 32'h0));
        pending_reqs.push_back(make_req(iprt_pkg::CmdLookup, 32'hFFFF_FFFF, 32'h0));
        pending_reqs.push_back(make_req(iprt_pkg::CmdLookup, 32'h0B00_00FF, 32'h0));
        pending_reqs.push_back(make_req(CmdUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(iprt_pkg::CmdDelete, 32'h0B0F_0000, 32'hF0F0_0100));
        pending_reqs.push_back(make_req(iprt_pkg::CmdDelete, 32'h0A01_FFFF, 32'hFFFF_0000));
        pending_reqs.push_back(make_req(iprt_pkg::CmdLookup, 32'h0A01_0203, 32'h0));
        wait_quiet();
        // some interfaces down
        write_up_mask(8'h01);
        pending_reqs.push_back(make_req(iprt_pkg::CmdLookup, 32'h0A01_0203, 32'h0));
        pending_reqs.push_back(make_req(iprt_pkg::CmdLookup, 32'hFFFF_FFFF, 32'h0));
        // fill past full, then one lookup
        for (int i = 0; i < Depth; i++)
            pending_reqs.push_back(make_req(iprt_pkg::CmdAdd, $urandom(), rand_mask()));
        pending_reqs.push_back(make_req(iprt_pkg::CmdLookup, $urandom(), 32'h0));
        wait_quiet();

        // random phases, each under its own interface mask
        for (int ph = 0; ph < 5; ph++) begin
            write_up_mask(phase_masks[ph]);
            for (int n = 0; n < 180; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 35 || known_dest.size() == 0) begin
                    r = make_req(iprt_pkg::CmdAdd, $urandom(), rand_mask());
                    if (rt_count + pending_reqs.size() > 26 && $urandom_range(0, 1))
                        r.cmd = iprt_pkg::CmdDelete;
                    known_dest.push_back(r.dest);
                    known_mask.push_back(r.mask);
                end else if (pick < 60) begin
                    // delete of a route seen before, mostly a hit
                    int k;
                    k = $urandom_range(0, known_dest.size() - 1);
                    r = make_req(iprt_pkg::CmdDelete,
                                 known_dest[k] ^ ($urandom() & ~known_mask[k]),
                                 known_mask[k]);
                    if ($urandom_range(0, 4) == 0) r.dest = $urandom();
                end else if (pick < 97) begin
                    int k;
                    k = $urandom_range(0, known_dest.size() - 1);
                    r = make_req(iprt_pkg::CmdLookup, ($urandom_range(0, 3) == 0) ? $urandom() :
                                 known_dest[k] ^ ($urandom() >> $urandom_range(0, 32)),
                                 $urandom());
                end else begin
                    r = make_req(CmdUnused, $urandom(), $urandom());
                end
                pending_reqs.push_back(r);
                if (known_dest.size() > 64) begin
                    void'(known_dest.pop_front());
                    void'(known_mask.pop_front());
                end
            end
            if (ph == 2) begin
                // sender holds off until all answers are back
                while (pending_reqs.size() > 90) @(posedge i_clk);
                drain_hold = 1'b1;
                while (expected_answers.size() > 0 || s_axis_tvalid) @(posedge i_clk);
                repeat (20) @(posedge i_clk);
                drain_hold = 1'b0;
            end
            wait_quiet();
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
